// ----- rtl/nts_pkg.sv -----
// shared types and constants of the hevc unit type splitter
package nts_pkg;

   // default divert mask: unit types 30, 38 and 39 go to the side output
   localparam logic [63:0] MASK_RESET  = 64'h0000_00C0_4000_0000;
   // header byte bits that carry the unit type
   localparam logic [7:0]  TYPE_FIELD  = 8'h7e;
   localparam logic [7:0]  ZERO_BYTE   = 8'h00;
   localparam logic [7:0]  START_BYTE  = 8'h01;
   // default depth of the queue between front and back
   localparam int          QUEUE_DEPTH = 4;

   // one input request
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   // one result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_to_side;
      logic       out_unit_start;
      logic [5:0] out_unit_type;
      logic       out_run_last;
      logic       out_frame_end;
      logic       out_side_seen;
   } rsp_type;

   // run of results caused by one request, in order:
   // held start code, zeros, the byte itself, start code flushed at frame end
   typedef struct packed {
      logic [2:0] a_len;      // 0, 3 or 4
      logic       side;       // route of the current unit
      logic [5:0] kind;       // type of the current unit
      logic [2:0] zeros;      // 0 to 4
      logic       has_byte;
      logic [7:0] data;
      logic [2:0] b_len;      // 0, 3 or 4, flushed as type 0 on main
      logic       last;
      logic       side_seen;
      logic [2:0] count;      // 1 to 5
   } desc_type;

endpackage

// ----- rtl/nts_front.sv -----
// front part: start code detection, unit routing and run descriptor build
module nts_front import nts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  req_type     req_data,
   input  logic        q_full,
   input  logic        csr_valid,
   input  logic [63:0] csr_data,
   output logic        q_push,
   output desc_type    q_data
);

   logic [63:0] mask_ff;
   logic [1:0]  zero_run_ff, zero_run_in;
   logic        await_ff, await_in;
   logic [2:0]  held_len_ff, held_len_in;
   logic        side_ff, side_in;
   logic [5:0]  kind_ff, kind_in;
   logic        div_ff, div_in;

   logic        accept;
   logic [7:0]  b;
   logic [7:0]  type_bits;
   logic [2:0]  z_mid;
   logic        has_byte;
   logic [2:0]  a_len;
   logic [2:0]  b_len;
   logic [2:0]  zeros;
   logic [2:0]  count;

   assign accept    = req_push && !q_full;
   assign b         = req_data.in_byte;
   assign type_bits = (b & TYPE_FIELD) >> 1;

   // state update and descriptor fields
   always_comb begin
      zero_run_in = zero_run_ff;
      await_in    = 1'b0;
      held_len_in = 3'd0;
      side_in     = side_ff;
      kind_in     = kind_ff;
      div_in      = div_ff;
      a_len       = 3'd0;
      z_mid       = 3'd0;
      has_byte    = 1'b0;
      b_len       = 3'd0;
      zeros       = 3'd0;

      // header byte of a held start code decides the route of the new unit
      if (await_ff) begin
         kind_in = type_bits[5:0];
         side_in = mask_ff[type_bits[5:0]];
         div_in  = div_ff | mask_ff[type_bits[5:0]];
         a_len   = held_len_ff;
      end

      if (b == ZERO_BYTE) begin
         if (zero_run_ff == 2'd3) begin
            z_mid = 3'd1;
         end else begin
            zero_run_in = zero_run_ff + 2'd1;
         end
      end else if (b == START_BYTE && zero_run_ff >= 2'd2) begin
         held_len_in = {1'b0, zero_run_ff} + 3'd1;
         zero_run_in = 2'd0;
         await_in    = 1'b1;
      end else begin
         z_mid       = {1'b0, zero_run_ff};
         zero_run_in = 2'd0;
         has_byte    = 1'b1;
      end

      zeros = z_mid;
      if (req_data.in_last) begin
         zeros = z_mid + {1'b0, zero_run_in};
         if (await_in) begin
            b_len = held_len_in;
         end
      end
      count = a_len + zeros + {2'd0, has_byte} + b_len;
   end

   // descriptor towards the queue
   always_comb begin
      q_data.a_len     = a_len;
      q_data.side      = side_in;
      q_data.kind      = kind_in;
      q_data.zeros     = zeros;
      q_data.has_byte  = has_byte;
      q_data.data      = b;
      q_data.b_len     = b_len;
      q_data.last      = req_data.in_last;
      q_data.side_seen = div_in;
      q_data.count     = count;
   end

   assign q_push = accept && (count != 3'd0);

   // divert mask register
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
      end else if (csr_valid) begin
         mask_ff <= csr_data;
      end
   end

   // per-frame parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_run_ff <= 2'd0;
         await_ff    <= 1'b0;
         held_len_ff <= 3'd0;
         side_ff     <= 1'b0;
         kind_ff     <= 6'd0;
         div_ff      <= 1'b0;
      end else if (accept) begin
         if (req_data.in_last) begin
            zero_run_ff <= 2'd0;
            await_ff    <= 1'b0;
            held_len_ff <= 3'd0;
            side_ff     <= 1'b0;
            kind_ff     <= 6'd0;
            div_ff      <= 1'b0;
         end else begin
            zero_run_ff <= zero_run_in;
            await_ff    <= await_in;
            held_len_ff <= held_len_in;
            side_ff     <= side_in;
            kind_ff     <= kind_in;
            div_ff      <= div_in;
         end
      end
   end

endmodule

// ----- rtl/nts_queue.sv -----
// short descriptor queue between front and back
module nts_queue import nts_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_data,
   input  logic     pop,
   output desc_type head,
   output logic     full,
   output logic     empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   desc_type        mem [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/nts_back.sv -----
// back part: expands run descriptors into result bytes, one per cycle while the output slot is free or popped
module nts_back import nts_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  desc_type head,
   input  logic     q_empty,
   output logic     q_pop,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;
   logic [2:0] k_ff, k_in;
   logic       load;
   rsp_type    res;
   logic [3:0] kk, la, zz, hb, lb, j, n;

   assign load = !q_empty && (!out_valid_ff || rsp_pop);

   // result at position k of the current descriptor
   always_comb begin
      kk = {1'b0, k_ff};
      la = {1'b0, head.a_len};
      zz = {1'b0, head.zeros};
      hb = {3'd0, head.has_byte};
      lb = {1'b0, head.b_len};
      n  = {1'b0, head.count};
      j  = kk - la - zz - hb;

      res.out_byte       = ZERO_BYTE;
      res.out_to_side    = head.side;
      res.out_unit_start = 1'b0;
      res.out_unit_type  = head.kind;
      if (kk < la) begin
         // held start code of the new unit
         res.out_byte       = (kk == la - 4'd1) ? START_BYTE : ZERO_BYTE;
         res.out_unit_start = (kk == 4'd0);
      end else if (kk < la + zz) begin
         res.out_byte = ZERO_BYTE;
      end else if (head.has_byte && kk == la + zz) begin
         res.out_byte = head.data;
      end else begin
         // start code left without header at frame end
         res.out_byte       = (j == lb - 4'd1) ? START_BYTE : ZERO_BYTE;
         res.out_unit_start = (j == 4'd0);
         res.out_to_side    = 1'b0;
         res.out_unit_type  = 6'd0;
      end
      res.out_run_last  = (kk == n - 4'd1);
      res.out_frame_end = head.last && res.out_run_last;
      res.out_side_seen = res.out_frame_end && head.side_seen;
   end

   // output slot and position control
   always_comb begin
      out_valid_in = out_valid_ff;
      k_in         = k_ff;
      q_pop        = 1'b0;
      if (load) begin
         out_valid_in = 1'b1;
         if (res.out_run_last) begin
            k_in  = 3'd0;
            q_pop = 1'b1;
         end else begin
            k_in = k_ff + 3'd1;
         end
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         k_ff         <= 3'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         k_ff         <= k_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= res;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ----- rtl/hevc_nal_type_splitter_top.sv -----
// top level of the hevc annex b unit type splitter
//
//   channel   ports                                direction
//   request   req_push, req_full, req_data         in
//   result    rsp_empty, rsp_pop, rsp_data         out
//   csr       csr_valid, csr_ready, csr_data       in (divert mask)
//
// one request is taken per cycle while the descriptor queue has room; a
// request makes 0 to 5 result bytes, which leave one per cycle from the
// output register while the result side pops. the first result of a request
// passes the descriptor queue and then the output register on its way to the
// result ports. synchronous reset clears parser state, queue and output slot;
// the mask returns to types 30, 38 and 39. either side may stall on its own.
module hevc_nal_type_splitter_top import nts_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_data
);

   logic     q_push, q_pop, q_full, q_empty;
   desc_type q_in, q_head;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;

   // request parsing
   nts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .q_full    (q_full),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   // decoupling queue
   nts_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // result expansion
   nts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- verif/tb_hevc_nal_type_splitter_top.sv -----
// testbench of the hevc unit type splitter: directed and random framed byte streams against a predictor
`timescale 1ns / 1ps

module tb_hevc_nal_type_splitter_top;
   import nts_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int ITEMS_PER_PHASE = 18;
   localparam int NUM_PHASES = 6;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   req_type     req_data = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [63:0] csr_data = '0;

   hevc_nal_type_splitter_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // requests waiting to be driven, routed bytes still due
   req_type pending_reqs [$];
   rsp_type routed_due [$];
   rsp_type step_bytes [$];
   int      faults = 0;
   int      items_sent = 0;
   bit      sender_idles = 1'b1;
   bit      receiver_idles = 1'b1;
   int      tx_wait = 0;
   int      rx_wait = 0;
   int      quiet_cycles = 0;

   // predictor state: mask copy and per-frame parser state
   logic [63:0] div_mask = MASK_RESET;
   logic [1:0]  zeros_held = '0;
   logic        awaiting_hdr = 1'b0;
   logic [2:0]  held_len = '0;
   logic        cur_side = 1'b0;
   logic [5:0]  cur_type = '0;
   logic        side_hit = 1'b0;

   // random gap length: mostly none or short, a few long
   function automatic int draw_gap(input bit on);
      int r;
      if (!on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic put_byte(input logic [7:0] b, input logic side, input logic start,
                           input logic [5:0] kind);
      rsp_type r;
      r = '0;
      r.out_byte = b;
      r.out_to_side = side;
      r.out_unit_start = start;
      r.out_unit_type = kind;
      step_bytes = {step_bytes, r};
   endtask

   // start code of 3 or 4 bytes, first zero flagged as unit start
   task automatic put_code(input logic [2:0] len, input logic side, input logic [5:0] kind);
      int zeros;
      zeros = (len >= 3'd4) ? 3 : 2;
      for (int i = 0; i < zeros; i++) put_byte(ZERO_BYTE, side, i == 0, kind);
      put_byte(START_BYTE, side, 1'b0, kind);
   endtask

   // predict the routed bytes that one stream byte releases
   task automatic route_byte(input logic [7:0] b, input logic lst);
      int n;
      step_bytes.delete();
      if (awaiting_hdr) begin
         cur_type = 6'((b & TYPE_FIELD) >> 1);
         cur_side = div_mask[cur_type];
         if (cur_side) side_hit = 1'b1;
         put_code(held_len, cur_side, cur_type);
         awaiting_hdr = 1'b0;
         held_len = '0;
      end
      if (b == ZERO_BYTE) begin
         // a fourth zero pushes the oldest held zero out with the current unit
         if (zeros_held == 2'd3) put_byte(ZERO_BYTE, cur_side, 1'b0, cur_type);
         else zeros_held = zeros_held + 2'd1;
      end else if (b == START_BYTE && zeros_held >= 2'd2) begin
         held_len = 3'(zeros_held) + 3'd1;
         zeros_held = '0;
         awaiting_hdr = 1'b1;
      end else begin
         for (int i = 0; i < zeros_held; i++) put_byte(ZERO_BYTE, cur_side, 1'b0, cur_type);
         zeros_held = '0;
         put_byte(b, cur_side, 1'b0, cur_type);
      end
      if (lst) begin
         for (int i = 0; i < zeros_held; i++) put_byte(ZERO_BYTE, cur_side, 1'b0, cur_type);
         // a start code with no header leaves as type 0 on main
         if (awaiting_hdr) put_code(held_len, 1'b0, 6'd0);
         n = step_bytes.size();
         if (n > 0) begin
            step_bytes[n - 1].out_frame_end = 1'b1;
            step_bytes[n - 1].out_side_seen = side_hit;
         end
         zeros_held = '0;
         awaiting_hdr = 1'b0;
         held_len = '0;
         cur_side = 1'b0;
         cur_type = '0;
         side_hit = 1'b0;
      end
      n = step_bytes.size();
      if (n > 0) step_bytes[n - 1].out_run_last = 1'b1;
      routed_due = {routed_due, step_bytes};
   endtask

   task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $error("%s expected %0h got %0h", name, want, got);
         faults++;
      end
   endtask

   // request driver with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         tx_wait <= 0;
      end else if (!req_push || !req_full) begin
         if (tx_wait != 0) begin
            req_push <= 1'b0;
            tx_wait <= tx_wait - 1;
         end else if (pending_reqs.size() != 0) begin
            req_data <= pending_reqs.pop_front();
            req_push <= 1'b1;
            tx_wait <= draw_gap(sender_idles);
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // result monitor: checks routed bytes, predicts accepted requests, tracks mask writes
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      int stall;
      if (reset) begin
         rsp_pop <= 1'b0;
         rx_wait <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got = rsp_data;
            if (routed_due.size() == 0) begin
               $error("unexpected routed byte %0h", got.out_byte);
               faults++;
            end else begin
               want = routed_due.pop_front();
               compare_field("out_byte", want.out_byte, got.out_byte);
               compare_field("out_to_side", 8'(want.out_to_side), 8'(got.out_to_side));
               compare_field("out_unit_start", 8'(want.out_unit_start), 8'(got.out_unit_start));
               compare_field("out_unit_type", 8'(want.out_unit_type), 8'(got.out_unit_type));
               compare_field("out_run_last", 8'(want.out_run_last), 8'(got.out_run_last));
               compare_field("out_frame_end", 8'(want.out_frame_end), 8'(got.out_frame_end));
               compare_field("out_side_seen", 8'(want.out_side_seen), 8'(got.out_side_seen));
            end
            stall = draw_gap(receiver_idles);
            rsp_pop <= (stall == 0);
            rx_wait <= stall;
         end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            rsp_pop <= (rx_wait == 1);
         end else begin
            rsp_pop <= 1'b1;
         end
         if (req_push && !req_full) route_byte(req_data.in_byte, req_data.in_last);
         if (csr_valid && csr_ready) div_mask = csr_data;
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // queue one frame, flag on its final byte
   task automatic queue_frame(input logic [7:0] frame_bytes [$]);
      req_type r;
      foreach (frame_bytes[i]) begin
         r.in_byte = frame_bytes[i];
         r.in_last = (i == frame_bytes.size() - 1);
         pending_reqs = {pending_reqs, r};
         items_sent++;
      end
   endtask

   // random frame: mostly well-formed units with random payload, else raw noise
   task automatic add_random_frame();
      logic [7:0] frame_bytes [$];
      logic [7:0] hdr;
      logic [5:0] kind;
      int units;
      int pick;
      if ($urandom_range(0, 99) < 80) begin
         units = $urandom_range(1, 3);
         if ($urandom_range(0, 3) == 0) frame_bytes = {frame_bytes, 8'($urandom_range(2, 255))};
         for (int u = 0; u < units; u++) begin
            repeat ($urandom_range(0, 5) < 4 ? 0 : $urandom_range(1, 3))
               frame_bytes = {frame_bytes, ZERO_BYTE};
            if ($urandom_range(0, 1)) frame_bytes = {frame_bytes, ZERO_BYTE};
            frame_bytes = {frame_bytes, ZERO_BYTE};
            frame_bytes = {frame_bytes, ZERO_BYTE};
            frame_bytes = {frame_bytes, START_BYTE};
            // a few frames stop on a bare start code
            if (u == units - 1 && $urandom_range(0, 9) == 0) break;
            pick = $urandom_range(0, 9);
            case (pick)
               0: kind = 6'd30;
               1: kind = 6'd38;
               2: kind = 6'd39;
               3: kind = 6'd0;
               4: kind = 6'd63;
               default: kind = 6'($urandom_range(0, 63));
            endcase
            hdr = 8'($urandom_range(0, 255));
            hdr[6:1] = kind;
            frame_bytes = {frame_bytes, hdr};
            repeat ($urandom_range(0, 5)) begin
               pick = $urandom_range(0, 9);
               if (pick < 2) frame_bytes = {frame_bytes, ZERO_BYTE};
               else if (pick == 2) frame_bytes = {frame_bytes, START_BYTE};
               else if (pick == 3) frame_bytes = {frame_bytes, 8'h03};
               else frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
            end
         end
      end else begin
         repeat ($urandom_range(1, 10)) begin
            pick = $urandom_range(0, 3);
            if (pick == 0) frame_bytes = {frame_bytes, ZERO_BYTE};
            else if (pick == 1) frame_bytes = {frame_bytes, START_BYTE};
            else frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
         end
      end
      queue_frame(frame_bytes);
   endtask

   // wait until nothing is in flight, then let trailing no-result requests settle
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_push || routed_due.size() != 0);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_mask(input logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // stimulus: directed frames at reset mask, then random phases over several masks
   initial begin
      logic [7:0]  frame_bytes [$];
      logic [63:0] masks [NUM_PHASES];
      int          goal;
      masks[0] = MASK_RESET;
      masks[1] = '1;
      masks[2] = '0;
      masks[3] = {$urandom, $urandom};
      masks[4] = 64'h8000_0000_0000_0001;
      masks[5] = {$urandom, $urandom};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // leading byte, diverted type 30, long zero run, type 38 with top type bits,
      // zero header starting the next code, header mapping to type 0
      frame_bytes = '{8'hff, 8'h00, 8'h00, 8'h01, 8'h3c, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h01, 8'h4c, 8'h7f, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
                      8'h01, 8'h80};
      queue_frame(frame_bytes);
      // start code ending the frame
      frame_bytes = '{8'h00, 8'h00, 8'h01};
      queue_frame(frame_bytes);
      // lone zero flushed at frame end
      frame_bytes = '{8'h00};
      queue_frame(frame_bytes);
      wait_idle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_mask(masks[p]);
         sender_idles = (p != 1) && ($urandom_range(0, 3) != 0);
         receiver_idles = (p != 2) && ($urandom_range(0, 3) != 0);
         goal = items_sent + ITEMS_PER_PHASE;
         while (items_sent < goal) add_random_frame();
         wait_idle();
      end

      if (routed_due.size() != 0) begin
         $error("%0d routed bytes never arrived", routed_due.size());
         faults++;
      end
      if (faults == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
